// File: src/itrd_pkg.sv
package itrd_pkg;

  localparam int NUM_WIDTH_DEF = 64;
  localparam int RADIX_W       = 6;
  localparam int CHAR_W        = 7;
  localparam int COUNT_W       = 7;
  localparam int BITS_PER_STEP = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_BASE  = 6'd10;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0]  ASCII_NINE = 7'h39;
  localparam logic [CHAR_W-1:0]  ASCII_A    = 7'h41;
  localparam logic [CHAR_W-1:0]  ASCII_Z    = 7'h5a;

  typedef struct packed {
    logic load;      // capture number and radix, clear digit count
    logic step;      // one slice of the long division
    logic push;      // store remainder as a character, bump count
    logic ptr_init;  // point the read side at the top of the stack
    logic ptr_dec;
    logic out_load;  // move stack top into the output register
  } cmd_t;

  typedef struct packed {
    logic quot_zero;
    logic stack_full;
    logic ptr_zero;
    logic out_free;
  } status_t;

endpackage

// File: src/integer_to_radix_digits.sv
// channel | handshake            | payload                             | words
// in      | in_valid, in_ready   | number, radix                       | one per conversion
// out     | out_valid, out_ready | digit_char, digit_count, last_digit | one per digit, msb first
//
// each digit comes out of the divider at 8 quotient bits per cycle and then comes back
// off the digit stack through a registered memory read.
// one item at a time; the last digit may wait in the output register while the
// next word is taken. reset clears the controller and the output valid only.
// a stalled output holds the controller in its load state.
module integer_to_radix_digits #(
  parameter int NUM_WIDTH = itrd_pkg::NUM_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [NUM_WIDTH-1:0]         number,
  input  logic [itrd_pkg::RADIX_W-1:0] radix,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [itrd_pkg::CHAR_W-1:0]  digit_char,
  output logic [itrd_pkg::COUNT_W-1:0] digit_count,
  output logic                         last_digit
);

  itrd_pkg::cmd_t    cmd;
  itrd_pkg::status_t status;

  itrd_ctrl #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  itrd_datapath #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .number      (number),
    .radix       (radix),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .digit_char  (digit_char),
    .digit_count (digit_count),
    .last_digit  (last_digit)
  );

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("output word overwritten before it was taken");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((digit_char >= itrd_pkg::ASCII_ZERO && digit_char <= itrd_pkg::ASCII_NINE)
                || (digit_char >= itrd_pkg::ASCII_A && digit_char <= itrd_pkg::ASCII_Z)))
    else $error("digit character out of range");

  a_count_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_count != '0 && digit_count <= itrd_pkg::COUNT_W'(NUM_WIDTH)))
    else $error("digit count out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new word taken while a conversion is running");
`endif

endmodule

// File: src/itrd_datapath.sv
module itrd_datapath #(
  parameter int NUM_WIDTH = itrd_pkg::NUM_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  itrd_pkg::cmd_t                  cmd,
  output itrd_pkg::status_t               status,
  input  logic [NUM_WIDTH-1:0]            number,
  input  logic [itrd_pkg::RADIX_W-1:0]    radix,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [itrd_pkg::CHAR_W-1:0]     digit_char,
  output logic [itrd_pkg::COUNT_W-1:0]    digit_count,
  output logic                            last_digit
);

  localparam int BITS = itrd_pkg::BITS_PER_STEP;
  localparam int PW   = ((NUM_WIDTH + BITS - 1) / BITS) * BITS;
  localparam int AW   = $clog2(NUM_WIDTH);
  localparam int RW   = itrd_pkg::RADIX_W;
  localparam int CW   = itrd_pkg::CHAR_W;
  localparam int NW   = itrd_pkg::COUNT_W;

  logic [PW-1:0]  value;
  logic [PW-1:0]  value_next;
  logic [RW-1:0]  base;
  logic [RW-1:0]  base_next;
  logic [RW-1:0]  rem;
  logic [RW-1:0]  rem_next;
  logic [NW-1:0]  count;
  logic [AW-1:0]  ptr;
  logic [CW-1:0]  rem_char;
  logic [CW-1:0]  rd_data;
  logic [CW-1:0]  stack_mem [NUM_WIDTH];

  // radix outside 2..36 is pinned to the nearest end
  always_comb begin
    if (radix < itrd_pkg::RADIX_MIN) begin
      base_next = itrd_pkg::RADIX_MIN;
    end else if (radix > itrd_pkg::RADIX_MAX) begin
      base_next = itrd_pkg::RADIX_MAX;
    end else begin
      base_next = radix;
    end
  end

  // restoring division, BITS quotient bits per cycle, msb first
  always_comb begin
    logic [RW:0]     t;
    logic [RW-1:0]   rr;
    logic [BITS-1:0] q;
    rr = rem;
    q  = '0;
    for (int i = 0; i < BITS; i++) begin
      t = {rr, value[PW-1-i]};
      if (t >= {1'b0, base}) begin
        rr = RW'(t - {1'b0, base});
        q[BITS-1-i] = 1'b1;
      end else begin
        rr = t[RW-1:0];
      end
    end
    rem_next   = rr;
    value_next = (value << BITS) | PW'(q);
  end

  always_comb begin
    if (rem < itrd_pkg::DEC_BASE) begin
      rem_char = itrd_pkg::ASCII_ZERO + CW'(rem);
    end else begin
      rem_char = itrd_pkg::ASCII_A + CW'(rem) - CW'(itrd_pkg::DEC_BASE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= PW'(number);
      base  <= base_next;
      rem   <= '0;
    end else if (cmd.step) begin
      value <= value_next;
      rem   <= rem_next;
    end else if (cmd.push) begin
      rem   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      count <= '0;
    end else if (cmd.push) begin
      count <= count + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ptr_init) begin
      ptr <= count[AW-1:0];
    end else if (cmd.ptr_dec) begin
      ptr <= ptr - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[count[AW-1:0]] <= rem_char;
    end
    rd_data <= stack_mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      digit_char  <= rd_data;
      digit_count <= count;
      last_digit  <= (ptr == '0);
    end
  end

  assign status.quot_zero  = (value == '0);
  assign status.stack_full = (count == NW'(NUM_WIDTH - 1));
  assign status.ptr_zero   = (ptr == '0);
  assign status.out_free   = !out_valid || out_ready;

endmodule

// File: src/itrd_ctrl.sv
module itrd_ctrl #(
  parameter int NUM_WIDTH = itrd_pkg::NUM_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  itrd_pkg::status_t status,
  output itrd_pkg::cmd_t    cmd
);

  localparam int BITS  = itrd_pkg::BITS_PER_STEP;
  localparam int STEPS = (NUM_WIDTH + BITS - 1) / BITS;
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_PUSH = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_LD   = 3'd4;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [SW-1:0] step;
  logic [SW-1:0] step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (step == SW'(STEPS - 1)) begin
          state_next = ST_PUSH;
        end else begin
          step_next = step + SW'(1);
        end
      end
      ST_PUSH: begin
        cmd.push = 1'b1;
        if (status.quot_zero || status.stack_full) begin
          cmd.ptr_init = 1'b1;
          state_next   = ST_RD;
        end else begin
          step_next  = '0;
          state_next = ST_DIV;
        end
      end
      // stack read is registered: this state waits for the data to land
      ST_RD: begin
        state_next = ST_LD;
      end
      ST_LD: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.ptr_zero) begin
            state_next = ST_IDLE;
          end else begin
            cmd.ptr_dec = 1'b1;
            state_next  = ST_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NW = itrd_pkg::NUM_WIDTH_DEF;
  localparam logic [NW-1:0] ALL_ONES = {NW{1'b1}};

  typedef struct packed {
    logic [itrd_pkg::CHAR_W-1:0]  ch;
    logic [itrd_pkg::COUNT_W-1:0] count;
    logic                         last;
  } digit_word_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [NW-1:0]                number = '0;
  logic [itrd_pkg::RADIX_W-1:0] radix = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [itrd_pkg::CHAR_W-1:0]  digit_char;
  logic [itrd_pkg::COUNT_W-1:0] digit_count;
  logic                         last_digit;

  digit_word_t expected_digits[$];
  int          mismatches = 0;
  int          hold_left = 0;
  int          pattern_left = 0;
  int          stall_pct = 0;

  integer_to_radix_digits #(.NUM_WIDTH(NW)) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .number(number),
    .radix(radix),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .digit_char(digit_char),
    .digit_count(digit_count),
    .last_digit(last_digit)
  );

  always #6 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // queue the characters of one conversion, most significant first
  function automatic void predict_conversion(input logic [NW-1:0] num,
                                             input logic [itrd_pkg::RADIX_W-1:0] rdx);
    logic [NW-1:0]               value;
    logic [NW-1:0]               base;
    logic [NW-1:0]               rem;
    logic [itrd_pkg::CHAR_W-1:0] chars[NW];
    int                          n;
    digit_word_t                 w;
    value = num;
    if (rdx < itrd_pkg::RADIX_MIN) begin
      base = NW'(itrd_pkg::RADIX_MIN);
    end else if (rdx > itrd_pkg::RADIX_MAX) begin
      base = NW'(itrd_pkg::RADIX_MAX);
    end else begin
      base = NW'(rdx);
    end
    n = 0;
    if (value == '0) begin
      chars[0] = itrd_pkg::ASCII_ZERO;
      n = 1;
    end else begin
      while (value != '0 && n < NW) begin
        rem = value % base;
        if (rem >= NW'(itrd_pkg::DEC_BASE)) begin
          chars[n] = itrd_pkg::ASCII_A
                   + itrd_pkg::CHAR_W'(rem - NW'(itrd_pkg::DEC_BASE));
        end else begin
          chars[n] = itrd_pkg::ASCII_ZERO + itrd_pkg::CHAR_W'(rem);
        end
        value = value / base;
        n++;
      end
    end
    for (int k = n - 1; k >= 0; k--) begin
      w.ch = chars[k];
      w.count = itrd_pkg::COUNT_W'(n);
      w.last = (k == 0);
      expected_digits.push_back(w);
    end
  endfunction

  // valid stays high after acceptance until the next call or a pause
  task automatic send_conversion(input logic [NW-1:0] num,
                                 input logic [itrd_pkg::RADIX_W-1:0] rdx);
    @(negedge clk);
    in_valid = 1'b1;
    number = num;
    radix = rdx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_conversion(num, rdx);
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  function automatic logic [NW-1:0] random_number();
    logic [63:0] raw;
    int          len;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return raw[NW-1:0];
      default: begin
        len = $urandom_range(1, NW);
        return raw[NW-1:0] & (ALL_ONES >> (NW - len));
      end
    endcase
  endfunction

  // receiver: random stall density that changes now and then, plus long holds
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      if (pattern_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
        pattern_left = $urandom_range(50, 400);
      end else begin
        pattern_left = pattern_left - 1;
      end
      out_ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    digit_word_t exp_w;
    if (!rst && out_valid && out_ready) begin
      if (expected_digits.size() == 0) begin
        $error("unexpected digit word: digit_char %0h", digit_char);
        mismatches++;
      end else begin
        exp_w = expected_digits.pop_front();
        if (digit_char !== exp_w.ch) begin
          $error("digit_char: expected %0h, actual %0h", exp_w.ch, digit_char);
          mismatches++;
        end
        if (digit_count !== exp_w.count) begin
          $error("digit_count: expected %0d, actual %0d", exp_w.count, digit_count);
          mismatches++;
        end
        if (last_digit !== exp_w.last) begin
          $error("last_digit: expected %0b, actual %0b", exp_w.last, last_digit);
          mismatches++;
        end
      end
    end
  end

  task automatic test_zero_and_single_digits();
    send_conversion('0, itrd_pkg::DEC_BASE);
    send_conversion('0, 6'd0);
    send_conversion('0, 6'd63);
    send_conversion(NW'(1), itrd_pkg::RADIX_MIN);
    send_conversion(NW'(9), itrd_pkg::DEC_BASE);
    pause_sender(3);
    send_conversion(NW'(10), 6'd11);
    send_conversion(NW'(35), itrd_pkg::RADIX_MAX);
    send_conversion(NW'(35), 6'd37);
    send_conversion(NW'(36), itrd_pkg::RADIX_MAX);
    send_conversion(NW'(1295), itrd_pkg::RADIX_MAX);
  endtask

  // full-width values across the radix range, out-of-range radix clamps to 2 or 36
  task automatic test_radix_limits();
    send_conversion(ALL_ONES, itrd_pkg::RADIX_MIN);
    send_conversion(ALL_ONES, 6'd0);
    send_conversion(ALL_ONES, 6'd1);
    pause_sender(17);
    send_conversion(ALL_ONES, itrd_pkg::DEC_BASE);
    send_conversion(ALL_ONES, 6'd16);
    send_conversion(ALL_ONES, itrd_pkg::RADIX_MAX);
    send_conversion(ALL_ONES, 6'd63);
    send_conversion({1'b1, {(NW-1){1'b0}}}, itrd_pkg::RADIX_MIN);
    send_conversion(64'hdead_beef_0123_4567, 6'd16);
  endtask

  task automatic test_random_traffic(input int items);
    logic [itrd_pkg::RADIX_W-1:0] rdx;
    int                           sent;
    sent = 0;
    while (sent < items) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 4) == 0) begin
          rdx = itrd_pkg::RADIX_W'($urandom_range(0, 63));
        end else begin
          rdx = itrd_pkg::RADIX_W'($urandom_range(2, 36));
        end
        send_conversion(random_number(), rdx);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        pause_sender($urandom_range(1, ($urandom_range(0, 1) == 1) ? 12 : 300));
      end
    end
  endtask

  // receiver holds off while short words keep coming, so the input stalls
  task automatic test_output_backpressure();
    @(posedge clk);
    hold_left = 1000;
    repeat (6) send_conversion(NW'($urandom_range(0, 65535)), 6'd16);
    pause_sender(1);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_zero_and_single_digits();
    test_radix_limits();
    test_output_backpressure();
    test_random_traffic(85);
    pause_sender(0);
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: integer_to_radix_digits.f
src/itrd_pkg.sv
src/itrd_datapath.sv
src/itrd_ctrl.sv
src/integer_to_radix_digits.sv
tb/testbench.sv
